/* sv/itaf_pkg.sv */
// shared types and constants for the integer to ascii formatter
package itaf_pkg;

	// input format selector codes
	localparam logic [1:0] CMD_DEC  = 2'd0;
	localparam logic [1:0] CMD_BIN  = 2'd1;
	localparam logic [1:0] CMD_HEX  = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam int ValueW     = 32;
	localparam int CharW      = 8;
	localparam int MaxResults = 40;
	localparam int CntW       = $clog2(MaxResults + 1);
	localparam int IdxW       = $clog2(ValueW);
	localparam int BcdDigits  = 10;
	localparam int BcdW       = 4 * BcdDigits;

	// most significant digit index per format
	localparam logic [IdxW-1:0] TopDec = IdxW'(BcdDigits - 1);
	localparam logic [IdxW-1:0] TopBin = IdxW'(ValueW - 1);
	localparam logic [IdxW-1:0] TopHex = IdxW'(ValueW / 4 - 1);

	localparam logic [CharW-1:0] AsciiZero  = 8'h30;
	localparam logic [CharW-1:0] AsciiAlpha = 8'h37;
	localparam logic [CharW-1:0] AsciiSpace = 8'h20;

	// job queue depth, a power of two so pointers wrap on their own
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic [1:0] {
		FMT_DEC,
		FMT_BIN,
		FMT_HEX
	} fmt_t;

	typedef struct packed {
		fmt_t              fmt;
		logic [ValueW-1:0] value;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_EMIT,
		B_SPACE
	} bstate_t;

endpackage

/* sv/itaf_cmd_if.sv */
// command channel: format selector and value
interface itaf_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

/* sv/itaf_char_if.sv */
// character channel: one ascii character and end of run flag
interface itaf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ascii_char;
	logic       last;

	modport source (output valid, output ascii_char, output last, input ready);
	modport sink (input valid, input ascii_char, input last, output ready);
endinterface

/* sv/itaf_front.sv */
// front end: takes commands, decodes the format and drops unused selectors
module itaf_front (
	itaf_cmd_if.sink         cmd_ch,
	input  itaf_pkg::q_status_t qst,
	output logic             push,
	output itaf_pkg::job_t   job
);
	import itaf_pkg::*;

	logic keep;

	// accept whenever the queue has room
	assign cmd_ch.ready = !qst.full;

	// format decode
	always_comb begin
		keep      = 1'b1;
		job.value = cmd_ch.value;
		unique case (cmd_ch.cmd)
			CMD_DEC: job.fmt = FMT_DEC;
			CMD_BIN: job.fmt = FMT_BIN;
			CMD_HEX: job.fmt = FMT_HEX;
			default: begin
				job.fmt = FMT_DEC;
				keep    = 1'b0;
			end
		endcase
	end

	// only real formats reach the queue
	assign push = cmd_ch.valid && cmd_ch.ready && keep;

endmodule

/* sv/itaf_queue.sv */
// small job queue between front end and converter
module itaf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  itaf_pkg::job_t      job_in,
	input  logic                pop,
	output itaf_pkg::job_t      job_out,
	output itaf_pkg::q_status_t qst
);
	import itaf_pkg::*;

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;

	assign qst.full  = cnt_q == QCntW'(QDepth);
	assign qst.empty = cnt_q == '0;
	assign job_out   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= QPtrW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= QPtrW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= QCntW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= QCntW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

/* sv/itaf_back.sv */
// back end: digit extraction, leading zero suppression and character output
module itaf_back #(
	parameter int GROUP_SIZE = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  itaf_pkg::job_t      job,
	input  itaf_pkg::q_status_t qst,
	output logic                pop,
	itaf_char_if.source         char_ch
);
	import itaf_pkg::*;

	localparam int GrpW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam logic [GrpW-1:0] GrpMax    = GrpW'(GROUP_SIZE - 1);
	localparam logic [GrpW-1:0] BinTopGrp = GrpW'((ValueW - 1) % GROUP_SIZE);

	bstate_t           state_q, state_d;
	fmt_t              fmt_q;
	logic [ValueW-1:0] val_q;
	logic [BcdW-1:0]   bcd_q;
	logic [BcdW-1:0]   bcd_adj;
	logic [IdxW-1:0]   step_q;
	logic [IdxW-1:0]   idx_q;
	logic [GrpW-1:0]   grp_q;
	logic [CntW-1:0]   cnt_q;
	logic              started_q;
	logic              ov_q;
	logic [CharW-1:0]  och_q;
	logic              olast_q;

	logic [3:0]       dig;
	logic [CharW-1:0] dig_char;
	logic [CharW-1:0] ch;
	logic             slot, nz, skip, cap, sp_need;
	logic             emit, lst, adv;

	// double dabble adjust, one nibble per bcd digit
	always_comb begin
		for (int k = 0; k < BcdDigits; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] > 4'd4) ?
				4'(bcd_q[4*k +: 4] + 4'd3) : bcd_q[4*k +: 4];
		end
	end

	// current digit by format
	always_comb begin
		case (fmt_q)
			FMT_DEC: dig = (idx_q < TopDec + 1'b1) ? bcd_q[{idx_q[3:0], 2'b00} +: 4] : '0;
			FMT_BIN: dig = {3'b000, val_q[idx_q]};
			FMT_HEX: dig = val_q[{idx_q[2:0], 2'b00} +: 4];
			default: dig = '0;
		endcase
		dig_char = (dig < 4'd10) ? CharW'(AsciiZero + dig) : CharW'(AsciiAlpha + dig);
	end

	// emit control
	always_comb begin
		slot    = !ov_q || char_ch.ready;
		nz      = dig != '0;
		skip    = !started_q && !nz && idx_q != '0;
		cap     = cnt_q == CntW'(MaxResults - 1);
		sp_need = fmt_q == FMT_BIN && grp_q == '0 && (started_q || nz);
		emit    = 1'b0;
		lst     = 1'b0;
		adv     = 1'b0;
		pop     = 1'b0;
		ch      = dig_char;
		unique case (state_q)
			B_IDLE: pop = !qst.empty;
			B_CONV: ;
			B_EMIT: begin
				if (skip) begin
					adv = 1'b1;
				end else if (slot) begin
					emit = 1'b1;
					lst  = cap || (!sp_need && idx_q == '0);
					adv  = !lst && !sp_need;
				end
			end
			B_SPACE: begin
				ch = AsciiSpace;
				if (slot) begin
					emit = 1'b1;
					lst  = cap || idx_q == '0;
					adv  = !lst;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!qst.empty) begin
					state_d = (job.fmt == FMT_DEC) ? B_CONV : B_EMIT;
				end
			end
			B_CONV: begin
				if (step_q == TopBin) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (emit && lst) begin
					state_d = B_IDLE;
				end else if (emit && sp_need) begin
					state_d = B_SPACE;
				end
			end
			B_SPACE: begin
				if (emit) begin
					state_d = lst ? B_IDLE : B_EMIT;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			ov_q      <= 1'b0;
			started_q <= 1'b0;
			cnt_q     <= '0;
			step_q    <= '0;
			idx_q     <= '0;
			grp_q     <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				started_q <= 1'b0;
				cnt_q     <= '0;
				step_q    <= '0;
				grp_q     <= BinTopGrp;
				case (job.fmt)
					FMT_DEC: idx_q <= TopDec;
					FMT_BIN: idx_q <= TopBin;
					default: idx_q <= TopHex;
				endcase
			end else begin
				if (state_q == B_CONV) begin
					step_q <= IdxW'(step_q + 1'b1);
				end
				if (adv) begin
					idx_q <= IdxW'(idx_q - 1'b1);
					grp_q <= (grp_q == '0) ? GrpMax : GrpW'(grp_q - 1'b1);
				end
				if (emit) begin
					cnt_q     <= CntW'(cnt_q + 1'b1);
					started_q <= 1'b1;
				end
			end
			// output register
			if (emit) begin
				ov_q <= 1'b1;
			end else if (char_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			fmt_q <= job.fmt;
			val_q <= job.value;
			bcd_q <= '0;
		end else if (state_q == B_CONV) begin
			bcd_q <= {bcd_adj[BcdW-2:0], val_q[ValueW-1]};
			val_q <= {val_q[ValueW-2:0], 1'b0};
		end
		if (emit) begin
			och_q   <= ch;
			olast_q <= lst;
		end
	end

	assign char_ch.valid      = ov_q;
	assign char_ch.ascii_char = och_q;
	assign char_ch.last       = olast_q;

endmodule

/* sv/integer_to_ascii_formatter.sv */
// integer to ascii formatter top level: front end, job queue and converter
// a job is loaded from the queue, run through the shift-add steps in decimal mode, then
// each suppressed leading zero is skipped and each character is emitted, one at a time
// characters leave one per cycle from the output register while the sink is ready; a hex
// or binary job goes from the queue straight to emission, a decimal job first through the
// conversion state; the two-entry queue lets the front accept while the converter is busy
// asynchronous reset empties the queue and idles the converter
module integer_to_ascii_formatter #(
	parameter int GROUP_SIZE = 4
) (
	input logic         clk,
	input logic         arst_n,
	itaf_cmd_if.sink    cmd_ch,
	itaf_char_if.source char_ch
);
	import itaf_pkg::*;

	job_t      push_job;
	job_t      pop_job;
	q_status_t qst;
	logic      push;
	logic      pop;

	// command decode
	itaf_front u_front (
		.cmd_ch (cmd_ch),
		.qst    (qst),
		.push   (push),
		.job    (push_job)
	);

	// decoupling queue
	itaf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (push_job),
		.pop     (pop),
		.job_out (pop_job),
		.qst     (qst)
	);

	// conversion and character output
	itaf_back #(
		.GROUP_SIZE (GROUP_SIZE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (pop_job),
		.qst     (qst),
		.pop     (pop),
		.char_ch (char_ch)
	);

	// queue can never be full and empty at once
	a_q_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(qst.full && qst.empty))
		else $error("queue status inconsistent");

	// an unused selector is dropped, never queued
	a_drop_none: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ch.valid && cmd_ch.ready && cmd_ch.cmd == CMD_NONE) |-> !push)
		else $error("unused selector queued");

	// every character shown is a digit, an upper-case hex letter or a space
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		char_ch.valid |-> ((char_ch.ascii_char >= 8'h30 && char_ch.ascii_char <= 8'h39) ||
			(char_ch.ascii_char >= 8'h41 && char_ch.ascii_char <= 8'h46) ||
			char_ch.ascii_char == AsciiSpace))
		else $error("character outside output set");

	// a job leaves the queue only when one is there
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qst.empty)
		else $error("pop from empty queue");

endmodule

/* bench/tb_integer_to_ascii_formatter.sv */
// testbench for the integer to ascii formatter: random commands checked against a text predictor
module tb_integer_to_ascii_formatter;
	timeunit 1ns;
	timeprecision 1ps;

	import itaf_pkg::*;

	localparam int GROUP      = 4;
	localparam int ITEMS      = 160;
	localparam int CALM_ITEMS = 30;
	localparam int STALL_MAX  = 2000;

	typedef struct {
		logic [CharW-1:0] ch;
		logic             last;
	} text_char_t;

	// predicts the character run of each accepted command and checks the output against it
	class text_scoreboard;
		text_char_t pending_chars[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction

		// format one accepted command into its expected characters
		function void note_cmd(logic [1:0] fmt, logic [ValueW-1:0] val);
			int unsigned  radix;
			int unsigned  rest;
			int unsigned  d;
			int           ndig;
			int           i;
			logic [3:0]   digs[ValueW];
			text_char_t   run[$];
			text_char_t   c;
			case (fmt)
				CMD_DEC: radix = 10;
				CMD_BIN: radix = 2;
				CMD_HEX: radix = 16;
				default: return;
			endcase
			// split into digits, least significant first
			rest = val;
			ndig = 0;
			while (rest != 0 && ndig < ValueW) begin
				digs[ndig] = 4'(rest % radix);
				rest = rest / radix;
				ndig++;
			end
			c.last = 1'b0;
			if (ndig == 0) begin
				c.ch = AsciiZero;
				run.push_back(c);
			end else begin
				for (i = ndig - 1; i >= 0; i--) begin
					d = digs[i];
					c.ch = (d < 10) ? AsciiZero + CharW'(d) : AsciiAlpha + CharW'(d);
					run.push_back(c);
					// grouping space after every GROUP-th binary digit
					if (fmt == CMD_BIN && (i % GROUP) == 0) begin
						c.ch = AsciiSpace;
						run.push_back(c);
					end
				end
			end
			// runs past the cap are cut short
			while (run.size() > MaxResults)
				void'(run.pop_back());
			run[run.size() - 1].last = 1'b1;
			foreach (run[k])
				pending_chars.push_back(run[k]);
		endfunction

		// compare one output character with the oldest prediction
		function void check_char(logic [CharW-1:0] ch, logic last);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected char %02h last %0b with nothing pending", ch, last);
				return;
			end
			want = pending_chars.pop_front();
			if (want.ch !== ch || want.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("char mismatch: expected %02h last %0b, got %02h last %0b",
						want.ch, want.last, ch, last);
			end
		endfunction
	endclass

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_vld = 1'b0;
	logic [1:0]        cmd_fmt = CMD_DEC;
	logic [ValueW-1:0] cmd_val = '0;
	logic              sink_rdy = 1'b0;
	logic              idling = 1'b0;
	int                stall_left = 0;
	int                quiet_cycles = 0;
	text_scoreboard    sb = new();

	itaf_cmd_if  cmd_ch();
	itaf_char_if char_ch();

	assign cmd_ch.valid  = cmd_vld;
	assign cmd_ch.cmd    = cmd_fmt;
	assign cmd_ch.value  = cmd_val;
	assign char_ch.ready = sink_rdy;

	integer_to_ascii_formatter #(.GROUP_SIZE(GROUP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_ch(cmd_ch),
		.char_ch(char_ch)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// output side back-pressure in random bursts while idling is set
	always @(posedge clk) begin
		if (!arst_n) begin
			sink_rdy <= 1'b0;
		end else if (!idling) begin
			sink_rdy <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			sink_rdy <= (stall_left == 1);
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 15);
			sink_rdy <= 1'b0;
		end else begin
			sink_rdy <= 1'b1;
		end
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_cmd(cmd_ch.cmd, cmd_ch.value);
			if (char_ch.valid && char_ch.ready)
				sb.check_char(char_ch.ascii_char, char_ch.last);
			if ((cmd_ch.valid && cmd_ch.ready) || (char_ch.valid && char_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("[integer_to_ascii_formatter] ERROR");
				$finish;
			end
		end
	end

	// offer one command, with an optional gap first, and wait for its transfer
	task automatic send_cmd(input logic [1:0] fmt, input logic [ValueW-1:0] val);
		if (idling && $urandom_range(0, 3) == 0) begin
			cmd_vld <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		cmd_vld <= 1'b1;
		cmd_fmt <= fmt;
		cmd_val <= val;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// value with a spread of magnitudes
	function automatic logic [ValueW-1:0] pick_value();
		int unsigned k;
		k = $urandom_range(0, 31);
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom >> k;
			2: return $urandom_range(0, 20);
			3: return (32'd1 << k);
			default: return (32'd1 << k) - 32'd1;
		endcase
	endfunction

	// stimulus
	initial begin
		int          done;
		logic [1:0]  fmt;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, extremes, digit boundaries and the unused selector
		idling = 1'b1;
		send_cmd(CMD_DEC, 32'd0);
		send_cmd(CMD_BIN, 32'd0);
		send_cmd(CMD_HEX, 32'd0);
		send_cmd(CMD_NONE, 32'd5);
		send_cmd(CMD_DEC, 32'hFFFF_FFFF);
		send_cmd(CMD_BIN, 32'hFFFF_FFFF);
		send_cmd(CMD_HEX, 32'hFFFF_FFFF);
		send_cmd(CMD_DEC, 32'd9);
		send_cmd(CMD_DEC, 32'd10);
		send_cmd(CMD_DEC, 32'd1_000_000_000);
		send_cmd(CMD_HEX, 32'h0000_000F);
		send_cmd(CMD_HEX, 32'h0000_0010);
		send_cmd(CMD_HEX, 32'hABCD_EF09);
		send_cmd(CMD_BIN, 32'd1);
		send_cmd(CMD_BIN, 32'd8);
		send_cmd(CMD_BIN, 32'h0000_0010);
		send_cmd(CMD_BIN, 32'h8000_0000);
		send_cmd(CMD_NONE, 32'hFFFF_FFFF);
		send_cmd(CMD_DEC, 32'd1);
		send_cmd(CMD_HEX, 32'h8000_0000);

		// random: each chunk turns idling on or off at random, calm at the end
		done = 0;
		while (done < ITEMS) begin
			if (done % 20 == 0)
				idling = (done < ITEMS - CALM_ITEMS) ? ($urandom_range(0, 3) != 0) : 1'b0;
			fmt = ($urandom_range(0, 11) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
			send_cmd(fmt, pick_value());
			if (fmt != CMD_NONE)
				done++;
		end
		cmd_vld <= 1'b0;
		// let the monitor log the final transfer before looking at the backlog
		@(posedge clk);

		// drain, then allow for stray characters
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("[integer_to_ascii_formatter] OK");
		else
			$display("[integer_to_ascii_formatter] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
sv/itaf_pkg.sv
sv/itaf_cmd_if.sv
sv/itaf_char_if.sv
sv/itaf_front.sv
sv/itaf_queue.sv
sv/itaf_back.sv
sv/integer_to_ascii_formatter.sv
bench/tb_integer_to_ascii_formatter.sv
